// ===== sv/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg: shared definitions for the frustum box cull block
// Item kinds, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package fbc_pkg;

    // Parameter defaults
    localparam int NUM_PLANES_DEF = 5;
    localparam int COORD_BITS_DEF = 24;

    // Fixed field widths
    localparam int NORMAL_BITS = 16;
    localparam int PIDX_W      = 3;
    localparam int AXES        = 3;
    localparam int M_TDATA_W   = 8;

    // Item kinds carried on s_tuser
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_TEST = 1'b1
    } req_t;

endpackage

`default_nettype wire

// ===== sv/frustum_box_cull.sv =====
// ----------------------------------------------------------------------------
// frustum_box_cull: view-frustum culling of axis-aligned boxes
// Keeps a small plane table and tests one box per cycle against every plane, unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per handshake. s_tuser selects the
//   kind: a load writes one plane (point and Q2.14 normal) into the table at
//   the slot given in the item, a test carries a box as low and high corner.
//   Every item gives exactly one result item on the master stream; bit 0 of
//   m_tdata is 1 when the box lies wholly outside some plane, and 0 for
//   loads. A load to a slot beyond the table is dropped but still answered.
//   An accepted item is captured in the input register, then passes through
//   the product register and the result register, which drives m_tvalid.
//   Throughput: one item per cycle unless the receiver stalls; all planes and
//   axes are evaluated side by side, two multipliers for each plane and axis.
//   A load takes effect for the very next item.
//   Reset clears the plane table (zero normals never cull) and empties the
//   pipeline. When the receiver stalls, each stage holds while it is full
//   and the one after it cannot take its item; s_tready stays high while
//   any stage has room.
// ----------------------------------------------------------------------------
`default_nettype none

module frustum_box_cull #(
    parameter int NUM_PLANES = fbc_pkg::NUM_PLANES_DEF,
    parameter int COORD_BITS = fbc_pkg::COORD_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // plane_index, a_x, a_y, a_z, b_x, b_y, b_z (lowest first), zero padded
    input  wire logic [((fbc_pkg::PIDX_W + 6*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // req_type
    input  wire logic                 s_tuser,
    // Result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // culled, zero padded
    output logic [fbc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PIDX_W = fbc_pkg::PIDX_W;
    localparam int NB     = fbc_pkg::NORMAL_BITS;
    localparam int AXES   = fbc_pkg::AXES;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = DIFF_W + NB;
    localparam int SUM_W  = PROD_W + 2;

    // ------------------------------------------------------------------
    // Unpack the input item
    // ------------------------------------------------------------------
    logic [PIDX_W-1:0]     s_plane_index;
    logic [COORD_BITS-1:0] s_a [AXES];
    logic [COORD_BITS-1:0] s_b [AXES];
    logic                  s_accept;

    assign s_plane_index = s_tdata[PIDX_W-1:0];

    for (genvar k = 0; k < AXES; k++) begin : g_unpack
        assign s_a[k] = s_tdata[PIDX_W + k*COORD_BITS +: COORD_BITS];
        assign s_b[k] = s_tdata[PIDX_W + (AXES + k)*COORD_BITS +: COORD_BITS];
    end

    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic v0_reg, v1_reg, m_valid_reg;
    logic out_ready, st1_ready;

    assign out_ready = !m_valid_reg || m_tready;
    assign st1_ready = !v1_reg || out_ready;
    assign s_tready  = !v0_reg || st1_ready;

    // ------------------------------------------------------------------
    // Plane table: one slot per plane, written when a load is accepted
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] pt_reg  [NUM_PLANES][AXES];
    logic signed [NB-1:0]         nrm_reg [NUM_PLANES][AXES];

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_table
        localparam logic [PIDX_W-1:0] SLOT = PIDX_W'(g);
        logic wr_en;

        assign wr_en = s_accept && (s_tuser == fbc_pkg::REQ_LOAD) && (s_plane_index == SLOT);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                for (int k = 0; k < AXES; k++) begin
                    pt_reg[g][k]  <= '0;
                    nrm_reg[g][k] <= '0;
                end
            end else if (wr_en) begin
                for (int k = 0; k < AXES; k++) begin
                    pt_reg[g][k]  <= s_a[k];
                    // normal sits in the low bits of the high-corner field
                    nrm_reg[g][k] <= NB'(s_b[k]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic                         req0_reg;
    logic signed [COORD_BITS-1:0] lo0_reg [AXES];
    logic signed [COORD_BITS-1:0] hi0_reg [AXES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_tready) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req0_reg <= s_tuser;
            for (int k = 0; k < AXES; k++) begin
                lo0_reg[k] <= s_a[k];
                hi0_reg[k] <= s_b[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: corner offsets times normal, registered
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_lo_next [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] prod_hi_next [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] prod_lo_reg  [NUM_PLANES][AXES];
    logic signed [PROD_W-1:0] prod_hi_reg  [NUM_PLANES][AXES];
    logic                     req1_reg;

    for (genvar g = 0; g < NUM_PLANES; g++) begin : g_prod
        for (genvar k = 0; k < AXES; k++) begin : g_axis
            logic signed [DIFF_W-1:0] diff_lo, diff_hi;

            assign diff_lo = DIFF_W'(lo0_reg[k]) - DIFF_W'(pt_reg[g][k]);
            assign diff_hi = DIFF_W'(hi0_reg[k]) - DIFF_W'(pt_reg[g][k]);
            assign prod_lo_next[g][k] = diff_lo * nrm_reg[g][k];
            assign prod_hi_next[g][k] = diff_hi * nrm_reg[g][k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (st1_ready) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_ready && v0_reg) begin
            req1_reg <= req0_reg;
            for (int g = 0; g < NUM_PLANES; g++) begin
                for (int k = 0; k < AXES; k++) begin
                    prod_lo_reg[g][k] <= prod_lo_next[g][k];
                    prod_hi_reg[g][k] <= prod_hi_next[g][k];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis minimum, sum, sign test; result register
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] axis_min [NUM_PLANES][AXES];
    logic signed [SUM_W-1:0]  least    [NUM_PLANES];
    logic [NUM_PLANES-1:0]    outside;
    logic                     culled_next;
    logic                     culled_reg;

    always_comb begin
        for (int g = 0; g < NUM_PLANES; g++) begin
            for (int k = 0; k < AXES; k++) begin
                axis_min[g][k] = (prod_lo_reg[g][k] < prod_hi_reg[g][k]) ?
                                 prod_lo_reg[g][k] : prod_hi_reg[g][k];
            end
            least[g]   = SUM_W'(axis_min[g][0]) + SUM_W'(axis_min[g][1])
                       + SUM_W'(axis_min[g][2]);
            // strictly positive: sign clear and not zero
            outside[g] = !least[g][SUM_W-1] && (least[g] != '0);
        end
        culled_next = (req1_reg == fbc_pkg::REQ_TEST) && (|outside);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && v1_reg) begin
            culled_reg <= culled_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(fbc_pkg::M_TDATA_W - 1)'(0), culled_reg};

endmodule

`default_nettype wire

// ===== sv/fbc_checker.sv =====
// ----------------------------------------------------------------------------
// fbc_checker: port-level checks for the frustum box cull block
// Watches the stream handshakes and the result padding over time.
// ----------------------------------------------------------------------------
`default_nettype none

module fbc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [fbc_pkg::M_TDATA_W-1:0] m_tdata
);

    // Drain the result side on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Hold a stalled result item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // Take input whenever the result register is empty
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Keep padding bits clear
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[fbc_pkg::M_TDATA_W-1:1] == '0))
        else $error("result padding bits set");

    // Accept inputs only when offered, so an idle input never fills the block
    a_no_ghost: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tvalid && !m_tvalid && $past(!s_tvalid) && $past(!s_tvalid, 2)
            && $past(!s_tvalid, 3) && $past(aresetn, 3) |=> !m_tvalid)
        else $error("result item without an input item");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for frustum_box_cull
// Streams plane loads and box tests into the block. A local copy of the plane
// table predicts the culled flag of every item at its input handshake, and the
// flag is compared on the result stream. Both stream sides idle at random.
// ----------------------------------------------------------------------------

module testbench;

    localparam int NPL         = fbc_pkg::NUM_PLANES_DEF;
    localparam int CW          = fbc_pkg::COORD_BITS_DEF;
    localparam int PIDX_W      = fbc_pkg::PIDX_W;
    localparam int NORMAL_BITS = fbc_pkg::NORMAL_BITS;
    localparam int M_TDATA_W   = fbc_pkg::M_TDATA_W;
    localparam int S_TDATA_W   = ((PIDX_W + 6*CW + 7) / 8) * 8;
    localparam int PAD_W       = S_TDATA_W - PIDX_W - 6*CW;
    localparam int N_RANDOM    = 1800;
    localparam int ONE_Q14     = 16384;

    typedef struct {
        fbc_pkg::req_t         kind;
        logic [PIDX_W-1:0]     slot;
        logic signed [CW-1:0]  ax, ay, az;
        logic signed [CW-1:0]  bx, by, bz;
        bit                    drain;   // wait for an empty pipeline first
    } cull_item_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic                    s_tuser  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;

    // Plane table as the block should hold it
    logic signed [NORMAL_BITS-1:0] nrm_x[NPL], nrm_y[NPL], nrm_z[NPL];
    logic signed [CW-1:0]          pnt_x[NPL], pnt_y[NPL], pnt_z[NPL];

    cull_item_t pending_q[$];
    bit         culled_q[$];

    int  n_sent    = 0;
    int  n_results = 0;
    int  n_errors  = 0;
    int  tx_wait   = 0;
    int  rx_wait   = 0;
    logic rx_hold  = 1'b0;

    frustum_box_cull u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Smaller of the two corner distances along one axis
    function automatic longint axis_least(longint n, longint p, longint lo, longint hi);
        longint dl, dh;
        dl = n * (lo - p);
        dh = n * (hi - p);
        return (dl < dh) ? dl : dh;
    endfunction

    // Apply one item to the plane table and return the expected culled flag
    function automatic bit cull_predict(cull_item_t it);
        longint least;
        bit     hit;
        hit = 1'b0;
        if (it.kind == fbc_pkg::REQ_LOAD) begin
            if (it.slot < NPL) begin
                pnt_x[it.slot] = it.ax;
                pnt_y[it.slot] = it.ay;
                pnt_z[it.slot] = it.az;
                nrm_x[it.slot] = it.bx[NORMAL_BITS-1:0];
                nrm_y[it.slot] = it.by[NORMAL_BITS-1:0];
                nrm_z[it.slot] = it.bz[NORMAL_BITS-1:0];
            end
        end else begin
            for (int i = 0; i < NPL; i++) begin
                least = axis_least(nrm_x[i], pnt_x[i], it.ax, it.bx)
                      + axis_least(nrm_y[i], pnt_y[i], it.ay, it.by)
                      + axis_least(nrm_z[i], pnt_z[i], it.az, it.bz);
                if (least > 0)
                    hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void add_item(fbc_pkg::req_t kind, int slot,
                                     int ax, int ay, int az,
                                     int bx, int by, int bz, bit drain = 1'b0);
        cull_item_t it;
        it.kind  = kind;
        it.slot  = PIDX_W'(slot);
        it.ax    = CW'(ax);
        it.ay    = CW'(ay);
        it.az    = CW'(az);
        it.bx    = CW'(bx);
        it.by    = CW'(by);
        it.bz    = CW'(bz);
        it.drain = drain;
        pending_q.push_back(it);
    endfunction

    // Coordinate either over the whole range or near the origin
    function automatic int pick_coord(bit near);
        logic signed [CW-1:0] c;
        if (near)
            c = CW'($urandom_range(0, 2048) - 1024);
        else
            c = CW'($urandom);
        return int'(c);
    endfunction

    // Sender: present queued items, draw a gap after each accepted one
    always @(posedge aclk) begin
        cull_item_t it;
        logic       next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
            tx_wait  = 0;
        end else begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready) begin
                culled_q.push_back(cull_predict(pending_q.pop_front()));
                n_sent++;
                tx_wait    = ((n_sent / 100) % 3 == 0) ? 0 : $urandom_range(0, 4);
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (pending_q.size() != 0 &&
                             (!pending_q[0].drain || culled_q.size() == 0)) begin
                    it = pending_q[0];
                    s_tdata    <= {{PAD_W{1'b0}}, it.bz, it.by, it.bx,
                                   it.az, it.ay, it.ax, it.slot};
                    s_tuser    <= it.kind;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: check each result item, draw a stall after it
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (culled_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("error: unexpected result item, culled=%0b", m_tdata[0]);
                end else begin
                    want = culled_q.pop_front();
                    if (m_tdata[0] !== want) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("error: result %0d culled expected %0b got %0b",
                                     n_results, want, m_tdata[0]);
                    end
                end
                rx_wait = ((n_results / 80) % 3 == 1) ? 0 : $urandom_range(0, 4);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_tready <= (rx_wait == 0) && !rx_hold;
        end
    end

    // Long receiver hold-off so the pipeline fills and backs up the input
    initial begin
        wait (n_sent >= 600);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, stimulus and end of run
    initial begin
        int  n_rand, n_load, n_test, seq;
        int  lo, hi, c[6];
        bit  near;

        for (int i = 0; i < NPL; i++) begin
            nrm_x[i] = '0; nrm_y[i] = '0; nrm_z[i] = '0;
            pnt_x[i] = '0; pnt_y[i] = '0; pnt_z[i] = '0;
        end

        // Directed: cleared table never culls
        add_item(fbc_pkg::REQ_TEST, 0, -8388608, -8388608, -8388608,
                 8388607, 8388607, 8388607);
        add_item(fbc_pkg::REQ_TEST, 7, 8388607, 8388607, 8388607,
                 8388607, 8388607, 8388607);
        // Plane z = 0 facing +z; upper normal bits must be ignored
        add_item(fbc_pkg::REQ_LOAD, 0, 0, 0, 0, 'hA50000, 'h5A0000, 'hFF0000 | ONE_Q14);
        // Boundary: box touching the plane is kept, one step above is culled
        add_item(fbc_pkg::REQ_TEST, 2, -8388608, -8388608, 0, 8388607, 8388607, 256);
        add_item(fbc_pkg::REQ_TEST, 5, -8388608, -8388608, 1, 8388607, 8388607, 256);
        // Low corner above high corner, used as given
        add_item(fbc_pkg::REQ_TEST, 0, 0, 0, 256, 0, 0, -1);
        add_item(fbc_pkg::REQ_TEST, 0, 0, 0, 256, 0, 0, 1);
        // Loads beyond the table are dropped
        add_item(fbc_pkg::REQ_LOAD, 5, 0, 0, 0, 0, 0, 0);
        add_item(fbc_pkg::REQ_LOAD, 7, 0, 0, 0, 0, 0, 0);
        add_item(fbc_pkg::REQ_LOAD, 6, 100, 100, 100, 0, 0, 0);
        add_item(fbc_pkg::REQ_TEST, 0, 0, 0, 1, 0, 0, 256);
        // Extreme normals and points in the other slots
        add_item(fbc_pkg::REQ_LOAD, 1, 8388607, 0, 0, -32768, 0, 0);
        add_item(fbc_pkg::REQ_LOAD, 2, 0, -8388608, 0, 0, 32767, 0);
        add_item(fbc_pkg::REQ_LOAD, 3, -8388608, 8388607, -8388608, 32767, -32768, 32767);
        add_item(fbc_pkg::REQ_LOAD, 4, 8388607, -8388608, 8388607, -1, -1, -1);
        add_item(fbc_pkg::REQ_TEST, 0, -8388608, -8388608, -8388608,
                 8388607, 8388607, 8388607);
        add_item(fbc_pkg::REQ_TEST, 0, 8388607, 8388607, 8388607,
                 -8388608, -8388608, -8388608);
        add_item(fbc_pkg::REQ_TEST, 0, -8388608, 8388607, -8388608,
                 -8388608, 8388607, -8388608);
        add_item(fbc_pkg::REQ_TEST, 7, 8388607, -8388608, 8388607,
                 8388607, -8388608, 8388607);
        add_item(fbc_pkg::REQ_TEST, 3, 8388607, 8388607, 8388607,
                 8388607, 8388607, 8388607);
        add_item(fbc_pkg::REQ_LOAD, 0, -8388608, -8388608, -8388608,
                 'hFFFFFF, 'hFFFFFF, 'hFFFFFF);
        add_item(fbc_pkg::REQ_TEST, 1, -8388608, -8388608, -8388608,
                 -8388608, -8388608, -8388608);

        // Random: plane loads followed by box tests, with some noise
        n_rand = 0;
        seq    = 0;
        while (n_rand < N_RANDOM) begin
            near   = $urandom_range(0, 2) != 0;
            n_load = $urandom_range(1, 5);
            for (int k = 0; k < n_load; k++) begin
                add_item(fbc_pkg::REQ_LOAD,
                         ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7)
                                                     : $urandom_range(0, 4),
                         pick_coord(near), pick_coord(near), pick_coord(near),
                         $urandom, $urandom, $urandom,
                         (k == 0) && (seq % 8 == 0));
                n_rand++;
            end
            n_test = $urandom_range(8, 30);
            for (int k = 0; k < n_test; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_item(fbc_pkg::req_t'($urandom_range(0, 1)), $urandom_range(0, 7),
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end else begin
                    for (int a = 0; a < 3; a++) begin
                        lo = pick_coord(near);
                        hi = ($urandom_range(0, 7) == 0) ? pick_coord(near)
                                                         : lo + $urandom_range(0, 1024);
                        c[a]     = lo;
                        c[a + 3] = hi;
                    end
                    add_item(fbc_pkg::REQ_TEST, $urandom_range(0, 7),
                             c[0], c[1], c[2], c[3], c[4], c[5]);
                end
                n_rand++;
            end
            seq++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain everything, then allow the pipeline latency to pass
        while (pending_q.size() != 0 || s_tvalid || culled_q.size() != 0)
            @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (n_errors == 0 && culled_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fbc_pkg.sv
sv/frustum_box_cull.sv
sv/fbc_checker.sv
tb/testbench.sv
